[hdl/mmr_pkg.sv]
// Shared constants for the mountain range position navigator.
// Used by mmr_position_navigator_top, mmr_peak_cell and mmr_link_stage; no dependencies.
`default_nettype none
package mmr_pkg;

   // default width of the position arithmetic; all sums wrap at this width
   localparam int POSITION_BITS_DEFAULT = 64;

   // fixed field widths of the transaction payloads
   localparam int NODE_BITS   = 63;
   localparam int LINK_BITS   = 64;
   localparam int HEIGHT_BITS = 6;

endpackage : mmr_pkg
`default_nettype wire

[hdl/mmr_peak_cell.sv]
// One cell of the peak-subtraction chain: tests one perfect-peak size 2^J-1.
// Walks the position and the position plus one together; depends on mmr_pkg.
`default_nettype none
module mmr_peak_cell #(
   parameter int POSITION_BITS = mmr_pkg::POSITION_BITS_DEFAULT,
   parameter int PEAK_ORDER    = mmr_pkg::POSITION_BITS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     up_valid,
   output logic                     up_ready,
   input  logic [POSITION_BITS-1:0] up_pos,
   input  logic [POSITION_BITS-1:0] up_rest_a,
   input  logic [POSITION_BITS-1:0] up_rest_b,
   input  logic [POSITION_BITS-1:0] up_count,
   output logic                     dn_valid,
   input  logic                     dn_ready,
   output logic [POSITION_BITS-1:0] dn_pos,
   output logic [POSITION_BITS-1:0] dn_rest_a,
   output logic [POSITION_BITS-1:0] dn_rest_b,
   output logic [POSITION_BITS-1:0] dn_count
);

   // peak size 2^J-1 and the leaf count of that peak, 2^(J-1)
   localparam logic [POSITION_BITS:0] PEAK_WIDE =
      ({{POSITION_BITS{1'b0}}, 1'b1} << PEAK_ORDER) - 1'b1;
   localparam logic [POSITION_BITS-1:0] PEAK = PEAK_WIDE[POSITION_BITS-1:0];
   localparam logic [POSITION_BITS-1:0] LEAVES =
      {{(POSITION_BITS-1){1'b0}}, 1'b1} << (PEAK_ORDER - 1);

   logic                     valid_ff;
   logic [POSITION_BITS-1:0] pos_ff,    pos_in;
   logic [POSITION_BITS-1:0] rest_a_ff, rest_a_in;
   logic [POSITION_BITS-1:0] rest_b_ff, rest_b_in;
   logic [POSITION_BITS-1:0] count_ff,  count_in;
   logic                     fits_a;
   logic                     fits_b;
   logic                     load;

   // subtract the peak where it still fits, count its leaves for the position
   always_comb begin
      fits_a    = (up_rest_a >= PEAK);
      fits_b    = (up_rest_b >= PEAK);
      pos_in    = up_pos;
      rest_a_in = fits_a ? (up_rest_a - PEAK) : up_rest_a;
      rest_b_in = fits_b ? (up_rest_b - PEAK) : up_rest_b;
      count_in  = fits_a ? (up_count + LEAVES) : up_count;
   end

   // advance when this cell is empty or its neighbor takes the transaction
   assign up_ready = !valid_ff || dn_ready;
   assign load     = up_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load && up_valid) begin
         pos_ff    <= pos_in;
         rest_a_ff <= rest_a_in;
         rest_b_ff <= rest_b_in;
         count_ff  <= count_in;
      end
   end

   assign dn_valid  = valid_ff;
   assign dn_pos    = pos_ff;
   assign dn_rest_a = rest_a_ff;
   assign dn_rest_b = rest_b_ff;
   assign dn_count  = count_ff;

endmodule : mmr_peak_cell
`default_nettype wire

[hdl/mmr_link_stage.sv]
// Final stage: turns the heights into sibling, parent and child positions.
// Depends on mmr_pkg for the output field widths; holds the result register.
`default_nettype none
module mmr_link_stage #(
   parameter int POSITION_BITS = mmr_pkg::POSITION_BITS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               up_valid,
   output logic                               up_ready,
   input  logic [POSITION_BITS-1:0]           up_pos,
   input  logic [POSITION_BITS-1:0]           up_rest_a,
   input  logic [POSITION_BITS-1:0]           up_rest_b,
   input  logic [POSITION_BITS-1:0]           up_count,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [mmr_pkg::HEIGHT_BITS-1:0]    rsp_node_height,
   output logic                               rsp_is_leaf,
   output logic [mmr_pkg::NODE_BITS-1:0]      rsp_leaf_number,
   output logic                               rsp_is_right_sibling,
   output logic [mmr_pkg::LINK_BITS-1:0]      rsp_parent_position,
   output logic [mmr_pkg::LINK_BITS-1:0]      rsp_sibling_position,
   output logic                               rsp_has_children,
   output logic [mmr_pkg::NODE_BITS-1:0]      rsp_left_child_position,
   output logic [mmr_pkg::NODE_BITS-1:0]      rsp_right_child_position
);
   import mmr_pkg::*;

   localparam logic [POSITION_BITS-1:0] ONE = {{(POSITION_BITS-1){1'b0}}, 1'b1};

   logic                     right;
   logic                     kids;
   logic [HEIGHT_BITS-1:0]   height;
   logic [HEIGHT_BITS:0]     up_shift;
   logic [POSITION_BITS-1:0] up_step;
   logic [POSITION_BITS-1:0] down_step;
   logic [POSITION_BITS-1:0] parent;
   logic [POSITION_BITS-1:0] sibling;
   logic [POSITION_BITS-1:0] left_child;
   logic [POSITION_BITS-1:0] right_child;

   logic                     valid_ff;
   logic [HEIGHT_BITS-1:0]   height_ff,  height_in;
   logic                     leaf_ff,    leaf_in;
   logic [NODE_BITS-1:0]     number_ff,  number_in;
   logic                     right_ff,   right_in;
   logic [LINK_BITS-1:0]     parent_ff,  parent_in;
   logic [LINK_BITS-1:0]     sibling_ff, sibling_in;
   logic                     kids_ff,    kids_in;
   logic [NODE_BITS-1:0]     lchild_ff,  lchild_in;
   logic [NODE_BITS-1:0]     rchild_ff,  rchild_in;
   logic                     load;

   // right sibling when the next position sits exactly one level higher
   always_comb begin
      height    = up_rest_a[HEIGHT_BITS-1:0];
      right     = ({1'b0, up_rest_b} == ({1'b0, up_rest_a} + 1'b1));
      kids      = (up_rest_a != '0);
      up_shift  = {1'b0, height} + 1'b1;
      up_step   = ONE << up_shift;
      down_step = ONE << height;
      parent    = up_pos + (right ? ONE : up_step);
      sibling   = right ? (up_pos + ONE - up_step) : (up_pos + up_step - ONE);
      left_child  = kids ? (up_pos - down_step) : '0;
      right_child = kids ? (up_pos - ONE) : '0;
   end

   // pack the result fields to their port widths
   always_comb begin
      height_in  = height;
      leaf_in    = !kids;
      number_in  = NODE_BITS'(up_count);
      right_in   = right;
      parent_in  = LINK_BITS'(parent);
      sibling_in = LINK_BITS'(sibling);
      kids_in    = kids;
      lchild_in  = NODE_BITS'(left_child);
      rchild_in  = NODE_BITS'(right_child);
   end

   // hold the result until the receiver takes it
   assign up_ready = !valid_ff || rsp_ready;
   assign load     = up_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load && up_valid) begin
         height_ff  <= height_in;
         leaf_ff    <= leaf_in;
         number_ff  <= number_in;
         right_ff   <= right_in;
         parent_ff  <= parent_in;
         sibling_ff <= sibling_in;
         kids_ff    <= kids_in;
         lchild_ff  <= lchild_in;
         rchild_ff  <= rchild_in;
      end
   end

   assign rsp_valid                = valid_ff;
   assign rsp_node_height          = height_ff;
   assign rsp_is_leaf              = leaf_ff;
   assign rsp_leaf_number          = number_ff;
   assign rsp_is_right_sibling     = right_ff;
   assign rsp_parent_position      = parent_ff;
   assign rsp_sibling_position     = sibling_ff;
   assign rsp_has_children         = kids_ff;
   assign rsp_left_child_position  = lchild_ff;
   assign rsp_right_child_position = rchild_ff;

endmodule : mmr_link_stage
`default_nettype wire

[hdl/mmr_position_navigator_top.sv]
// Mountain range position navigator: entry register, peak cell chain, link stage.
// Depends on mmr_pkg, mmr_peak_cell and mmr_link_stage.
//
// Usage:
//   Request channel (req_valid/req_ready) carries one post-order node position
//   per transaction. Response channel (rsp_valid/rsp_ready) returns exactly one
//   transaction per request, in order: height, leaf flag, leaves before the
//   position, right-sibling flag, parent, sibling and child positions.
//   The pipeline holds one entry register, one cell per peak size 2^J-1 for
//   J = POSITION_BITS down to 1, and the link stage with the result register.
//   Throughput is one transaction per cycle while rsp_ready is high; every
//   cell is a pipeline stage with its own valid bit, so a new position
//   enters each cycle.
//   When the receiver stalls, the result register holds and the chain keeps
//   filling its empty cells; req_ready drops only once every stage is full.
//   Synchronous reset empties all stages; payload registers are not reset,
//   and no configuration exists.
`default_nettype none
module mmr_position_navigator_top #(
   parameter int POSITION_BITS = mmr_pkg::POSITION_BITS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [mmr_pkg::NODE_BITS-1:0]      req_node_position,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [mmr_pkg::HEIGHT_BITS-1:0]    rsp_node_height,
   output logic                               rsp_is_leaf,
   output logic [mmr_pkg::NODE_BITS-1:0]      rsp_leaf_number,
   output logic                               rsp_is_right_sibling,
   output logic [mmr_pkg::LINK_BITS-1:0]      rsp_parent_position,
   output logic [mmr_pkg::LINK_BITS-1:0]      rsp_sibling_position,
   output logic                               rsp_has_children,
   output logic [mmr_pkg::NODE_BITS-1:0]      rsp_left_child_position,
   output logic [mmr_pkg::NODE_BITS-1:0]      rsp_right_child_position
);
   import mmr_pkg::*;

   // usable input bits: the narrower of the field and the arithmetic width
   localparam int IN_BITS = (POSITION_BITS < NODE_BITS) ? POSITION_BITS : NODE_BITS;
   localparam logic [POSITION_BITS-1:0] ONE = {{(POSITION_BITS-1){1'b0}}, 1'b1};

   logic                     ent_valid_ff;
   logic [POSITION_BITS-1:0] ent_pos_ff,  ent_pos_in;
   logic [POSITION_BITS-1:0] ent_next_ff, ent_next_in;

   logic                     ch_valid  [0:POSITION_BITS];
   logic                     ch_ready  [0:POSITION_BITS];
   logic [POSITION_BITS-1:0] ch_pos    [0:POSITION_BITS];
   logic [POSITION_BITS-1:0] ch_rest_a [0:POSITION_BITS];
   logic [POSITION_BITS-1:0] ch_rest_b [0:POSITION_BITS];
   logic [POSITION_BITS-1:0] ch_count  [0:POSITION_BITS];

   // mask the position and form the wrapped successor
   always_comb begin
      ent_pos_in  = POSITION_BITS'(req_node_position[IN_BITS-1:0]);
      ent_next_in = ent_pos_in + ONE;
   end

   assign req_ready = !ent_valid_ff || ch_ready[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         ent_valid_ff <= 1'b0;
      end else if (req_ready) begin
         ent_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         ent_pos_ff  <= ent_pos_in;
         ent_next_ff <= ent_next_in;
      end
   end

   // feed the head of the chain
   assign ch_valid[0]  = ent_valid_ff;
   assign ch_pos[0]    = ent_pos_ff;
   assign ch_rest_a[0] = ent_pos_ff;
   assign ch_rest_b[0] = ent_next_ff;
   assign ch_count[0]  = '0;

   // one cell per peak size, largest first
   for (genvar k = 0; k < POSITION_BITS; k++) begin : g_cell
      mmr_peak_cell #(
         .POSITION_BITS (POSITION_BITS),
         .PEAK_ORDER    (POSITION_BITS - k)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .up_valid  (ch_valid[k]),
         .up_ready  (ch_ready[k]),
         .up_pos    (ch_pos[k]),
         .up_rest_a (ch_rest_a[k]),
         .up_rest_b (ch_rest_b[k]),
         .up_count  (ch_count[k]),
         .dn_valid  (ch_valid[k+1]),
         .dn_ready  (ch_ready[k+1]),
         .dn_pos    (ch_pos[k+1]),
         .dn_rest_a (ch_rest_a[k+1]),
         .dn_rest_b (ch_rest_b[k+1]),
         .dn_count  (ch_count[k+1])
      );
   end

   mmr_link_stage #(
      .POSITION_BITS (POSITION_BITS)
   ) u_link (
      .clock                    (clock),
      .reset                    (reset),
      .up_valid                 (ch_valid[POSITION_BITS]),
      .up_ready                 (ch_ready[POSITION_BITS]),
      .up_pos                   (ch_pos[POSITION_BITS]),
      .up_rest_a                (ch_rest_a[POSITION_BITS]),
      .up_rest_b                (ch_rest_b[POSITION_BITS]),
      .up_count                 (ch_count[POSITION_BITS]),
      .rsp_valid                (rsp_valid),
      .rsp_ready                (rsp_ready),
      .rsp_node_height          (rsp_node_height),
      .rsp_is_leaf              (rsp_is_leaf),
      .rsp_leaf_number          (rsp_leaf_number),
      .rsp_is_right_sibling     (rsp_is_right_sibling),
      .rsp_parent_position      (rsp_parent_position),
      .rsp_sibling_position     (rsp_sibling_position),
      .rsp_has_children         (rsp_has_children),
      .rsp_left_child_position  (rsp_left_child_position),
      .rsp_right_child_position (rsp_right_child_position)
   );

`ifndef NO_ASSERTIONS
   // reset empties the result register
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // leaf flag and children flag are complements
   a_leaf_kids: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_is_leaf != rsp_has_children))
      else $error("leaf and children flags disagree");

   // a leaf reports cleared child positions
   a_leaf_no_child: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_is_leaf) |->
         (rsp_left_child_position == '0) && (rsp_right_child_position == '0))
      else $error("leaf with child positions");

   // a left sibling sits right below its parent
   a_left_parent: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_is_right_sibling) |->
         (POSITION_BITS'(rsp_parent_position - rsp_sibling_position) == ONE))
      else $error("left sibling not adjacent to parent");

   // the head of the chain never drops a waiting transaction
   a_entry_hold: assert property (@(posedge clock) disable iff (reset)
      (ent_valid_ff && !ch_ready[0]) |=> ent_valid_ff)
      else $error("entry transaction lost while stalled");
`endif

endmodule : mmr_position_navigator_top
`default_nettype wire
